FILE: rtl/core/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// sbsm_pkg
// Types and constants shared by the serial bank switch mapper.
// ----------------------------------------------------------------------------
package sbsm_pkg;

    // Bank geometry
    localparam int PRG_BANK_BYTES = 16384;
    localparam int CHR_BANK_BYTES = 4096;
    localparam int PRG_OFS_W      = $clog2(PRG_BANK_BYTES);   // 14
    localparam int CHR_OFS_W      = $clog2(CHR_BANK_BYTES);   // 12

    localparam int ADDR_W   = 16;
    localparam int PADDR_W  = 18;
    localparam int DATA_W   = 8;
    localparam int SREG_W   = 5;
    localparam int PBANK_W  = 4;
    localparam int COUNT_W  = 5;

    // Register and address constants
    localparam logic [SREG_W-1:0]  SHIFT_EMPTY   = 5'h10;
    localparam logic [SREG_W-1:0]  CTRL_RESET    = 5'h0C;
    localparam logic [COUNT_W-1:0] PRG_COUNT_RST = 5'd16;
    localparam logic [COUNT_W-1:0] PRG_COUNT_MAX = 5'd16;
    localparam logic [ADDR_W-1:0]  RAM_BASE      = 16'h6000;
    localparam logic [ADDR_W-1:0]  REG_BASE      = 16'h8000;

    // Access kinds
    typedef enum logic [1:0] {
        OP_CPU_READ  = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_PIC_READ  = 2'd2,
        OP_PIC_WRITE = 2'd3
    } t_opcode;

    // Destination memory
    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_PRG_ROM = 2'd1,
        TGT_PRG_RAM = 2'd2,
        TGT_PATTERN = 2'd3
    } t_target;

    // Register chosen by address bits 14..13 on the final serial write
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG_BANK = 2'd3
    } t_reg_sel;

    // Program banking modes, control bits 3..2
    typedef enum logic [1:0] {
        PM_32K_A   = 2'd0,
        PM_32K_B   = 2'd1,
        PM_FIX_LO  = 2'd2,
        PM_FIX_HI  = 2'd3
    } t_prg_mode;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   bus_address;
        logic [DATA_W-1:0]   write_data;
    } t_req;

    typedef struct packed {
        t_target             target;
        logic [PADDR_W-1:0]  physical_address;
        logic                store_enable;
        logic [DATA_W-1:0]   store_data;
        logic [1:0]          mirroring;
    } t_rsp;

    // Committed mapper registers
    typedef struct packed {
        logic [SREG_W-1:0]   shift;
        logic [SREG_W-1:0]   control;
        logic [SREG_W-1:0]   chr_low;
        logic [SREG_W-1:0]   chr_high;
        logic [PBANK_W-1:0]  prg_bank;
    } t_map_state;

endpackage

FILE: rtl/core/sbsm_xlate.sv
// ----------------------------------------------------------------------------
// sbsm_xlate
// Translates one bus request against the current mapper registers and
// produces the response plus the register values after the request.
// ----------------------------------------------------------------------------
module sbsm_xlate
    import sbsm_pkg::*;
(
    input  t_req                i_req,
    input  t_map_state          i_state,
    input  logic [COUNT_W-1:0]  i_prg_count,
    output t_map_state          o_state,
    output t_rsp                o_rsp
);

    logic [PBANK_W-1:0]  last_bank;
    logic [PBANK_W-1:0]  rom_bank;
    logic [SREG_W-1:0]   chr_bank;
    logic [SREG_W-1:0]   shift_val;
    logic                prg_upper;
    logic                chr_upper;
    t_prg_mode           prg_mode;
    t_reg_sel            sel;

    // Last program bank, count clamped to 1..16
    always_comb begin
        if (i_prg_count == '0) begin
            last_bank = '0;
        end else if (i_prg_count > PRG_COUNT_MAX) begin
            last_bank = '1;
        end else begin
            last_bank = PBANK_W'(i_prg_count - COUNT_W'(1));
        end
    end

    // Program ROM bank select
    assign prg_upper = i_req.bus_address[PRG_OFS_W];
    assign prg_mode  = t_prg_mode'(i_state.control[3:2]);

    always_comb begin
        unique case (prg_mode)
            PM_32K_A,
            PM_32K_B:  rom_bank = {i_state.prg_bank[PBANK_W-1:1], prg_upper};
            PM_FIX_LO: rom_bank = prg_upper ? i_state.prg_bank : '0;
            PM_FIX_HI: rom_bank = prg_upper ? last_bank : i_state.prg_bank;
            default:   rom_bank = '0;
        endcase
    end

    // Pattern bank select: one 8KB bank or two 4KB banks
    assign chr_upper = i_req.bus_address[CHR_OFS_W];

    always_comb begin
        if (!i_state.control[4]) begin
            chr_bank = {i_state.chr_low[SREG_W-1:1], chr_upper};
        end else begin
            chr_bank = chr_upper ? i_state.chr_high : i_state.chr_low;
        end
    end

    // Serial load register
    assign shift_val = {i_req.write_data[0], i_state.shift[SREG_W-1:1]};
    assign sel       = t_reg_sel'(i_req.bus_address[14:13]);

    always_comb begin
        o_state = i_state;
        o_rsp   = '{target: TGT_NONE, physical_address: '0, store_enable: 1'b0,
                    store_data: '0, mirroring: 2'b00};

        unique case (i_req.opcode)
            OP_PIC_READ,
            OP_PIC_WRITE: begin
                o_rsp.target           = TGT_PATTERN;
                o_rsp.physical_address = PADDR_W'({chr_bank,
                                                   i_req.bus_address[CHR_OFS_W-1:0]});
                o_rsp.store_enable     = (i_req.opcode == OP_PIC_WRITE);
            end
            OP_CPU_READ,
            OP_CPU_WRITE: begin
                if (i_req.bus_address >= REG_BASE) begin
                    if (i_req.opcode == OP_CPU_WRITE) begin
                        if (i_req.write_data[DATA_W-1]) begin
                            // reset write: clear serial load, force fixed-last mode
                            o_state.shift   = SHIFT_EMPTY;
                            o_state.control = i_state.control | CTRL_RESET;
                        end else if (!i_state.shift[0]) begin
                            o_state.shift = shift_val;
                        end else begin
                            // fifth write commits
                            o_state.shift = SHIFT_EMPTY;
                            unique case (sel)
                                SEL_CONTROL:  o_state.control  = shift_val;
                                SEL_CHR_LOW:  o_state.chr_low  = shift_val;
                                SEL_CHR_HIGH: o_state.chr_high = shift_val;
                                SEL_PRG_BANK: o_state.prg_bank = shift_val[PBANK_W-1:0];
                                default:      o_state.shift    = SHIFT_EMPTY;
                            endcase
                        end
                    end else begin
                        o_rsp.target           = TGT_PRG_ROM;
                        o_rsp.physical_address = {rom_bank,
                                                  i_req.bus_address[PRG_OFS_W-1:0]};
                    end
                end else if (i_req.bus_address >= RAM_BASE) begin
                    // 0x6000..0x7FFF: offset is the low 13 bits
                    o_rsp.target           = TGT_PRG_RAM;
                    o_rsp.physical_address = PADDR_W'(i_req.bus_address[12:0]);
                    o_rsp.store_enable     = (i_req.opcode == OP_CPU_WRITE);
                end
            end
            default: o_rsp.target = TGT_NONE;
        endcase

        o_rsp.store_data = o_rsp.store_enable ? i_req.write_data : '0;
        o_rsp.mirroring  = o_state.control[1:0];
    end

endmodule

FILE: rtl/core/serial_bank_switch_mapper_top.sv
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_top
// Cartridge bank mapper with a five-bit serially loaded register file.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready / i_req): one CPU or picture-bus
//   access per request. Response channel (o_out_valid / i_out_ready / o_rsp):
//   one response per request, in order, giving the target memory, the
//   physical byte address, the store strobe and data, and the mirroring mode.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): number of 16KB
//   program banks; always ready, write only while no request is in flight.
//   The response is registered after the single translate stage between the
//   request and the response register; throughput is one request per cycle
//   while o_in_ready is high.
//   Reset (synchronous, active low) restores the serial register to empty,
//   control to fixed-last mode, banks to zero and the bank count to 16.
//   When the receiver stalls, a skid register holds one more response; the
//   request side drops ready only once both are full.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_top
    import sbsm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_req                i_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_rsp                o_rsp,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [COUNT_W-1:0]  i_cfg_data
);

    t_map_state          r_state;
    t_map_state          n_state;
    logic [COUNT_W-1:0]  r_prg_count;
    t_rsp                r_out;
    t_rsp                r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;
    t_rsp                xl_rsp;
    logic                in_fire;
    logic                out_free;

    assign o_in_ready  = !r_skid_valid;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Translate stage
    sbsm_xlate u_xlate (
        .i_req       (i_req),
        .i_state     (r_state),
        .i_prg_count (r_prg_count),
        .o_state     (n_state),
        .o_rsp       (xl_rsp)
    );

    // Mapper registers and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{shift: SHIFT_EMPTY, control: CTRL_RESET, chr_low: '0,
                             chr_high: '0, prg_bank: '0};
            r_prg_count <= PRG_COUNT_RST;
        end else begin
            if (in_fire) begin
                r_state <= n_state;
            end
            if (i_cfg_valid) begin
                r_prg_count <= i_cfg_data;
            end
        end
    end

    // Response register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : xl_rsp;
        end else if (in_fire) begin
            r_skid <= xl_rsp;
        end
    end

    // Checks
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a response while output is empty");

    a_marker_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.shift != '0)
        else $error("serial register lost its marker bit");

    a_reset_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req.opcode == OP_CPU_WRITE && i_req.bus_address >= REG_BASE
         && i_req.write_data[DATA_W-1])
        |=> (r_state.shift == SHIFT_EMPTY && r_state.control[3:2] == 2'b11))
        else $error("reset write did not clear serial load");

    a_no_store_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.target == TGT_NONE) |-> !r_out.store_enable)
        else $error("store strobe with no target");

    a_mirror_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && out_free && !r_skid_valid)
        |=> (r_out.mirroring == r_state.control[1:0]))
        else $error("mirroring does not match committed control");

endmodule
